@@ rtl/texture_box_resample_macros.svh @@
// Assertion macros for the resampler
`ifndef TEXTURE_BOX_RESAMPLE_MACROS_SVH
`define TEXTURE_BOX_RESAMPLE_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define TBR_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define TBR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/tbr_pkg.sv @@
// Shared constants, types and helpers of the box-filter resampler
package tbr_pkg;

  // Image store depth; a power of two so read addresses wrap by truncation.
  localparam int IMAGE_DEPTH    = 131072;
  localparam int ADDR_W         = $clog2(IMAGE_DEPTH);
  localparam int MAX_DST_WIDTH  = 1024;
  localparam int MAX_DST_HEIGHT = 1024;
  localparam int MAX_SRC_DIM    = 2047;

  localparam int DIM_W     = 11;
  localparam int COL_W     = $clog2(MAX_DST_WIDTH);
  localparam int ROW_W     = $clog2(MAX_DST_HEIGHT);
  localparam int INDEX_W   = 17;
  localparam int PIXEL_W   = 32;
  localparam int CFG_IDX_W = 8;

  localparam int LANES  = 4;
  localparam int LANE_W = 8;
  localparam int LSUM_W = LANE_W + 2;

  // 16 fraction bits in the column step
  localparam int FRAC_W  = 16;
  localparam int FSTEP_W = DIM_W + FRAC_W;
  localparam int BASE_W  = COL_W + FSTEP_W;
  localparam int SUM_W   = BASE_W + 1;
  localparam int C_W     = SUM_W - FRAC_W;
  localparam int RSW_W   = 2 * DIM_W;

  // Divider sizing: covers both the column step and the row quotients
  localparam int ROWNUM_W = ROW_W + 2 + DIM_W;
  localparam int DIVD_W   = (FSTEP_W > ROWNUM_W) ? FSTEP_W : ROWNUM_W;
  localparam int DIVS_MAX = (4 * MAX_DST_HEIGHT > MAX_DST_WIDTH) ?
                            4 * MAX_DST_HEIGHT : MAX_DST_WIDTH;
  localparam int DIVS_W   = $clog2(DIVS_MAX + 1);
  localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = CFG_IDX_W'(3);

  typedef enum logic {
    KIND_LOAD,
    KIND_EMIT
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [INDEX_W-1:0]   index;
    logic [PIXEL_W-1:0]   pixel;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [DIM_W-1:0]      data;
  } cfg_wr_t;

  typedef struct packed {
    logic                start;
    logic [DIVD_W-1:0]   dividend;
    logic [DIVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DIVD_W-1:0]   quotient;
  } div_rsp_t;

  typedef struct packed {
    logic busy;
    logic at_origin;
  } bk_status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIVF_GO,
    BK_DIVF_WAIT,
    BK_DIVR1_GO,
    BK_DIVR1_WAIT,
    BK_DIVR2_GO,
    BK_DIVR2_WAIT,
    BK_ROW_MUL,
    BK_COL_MUL,
    BK_COL_ADD,
    BK_RD0,
    BK_RD1,
    BK_RD2,
    BK_RD3,
    BK_FIN
  } back_state_t;

  // Zero reads as one, anything above the cap reads as the cap.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > cap) r = cap;
    else r = v;
    return r;
  endfunction

endpackage

@@ rtl/tbr_ifs.sv @@
// Channel interfaces: input items, result items and configuration writes
interface tbr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [tbr_pkg::INDEX_W-1:0] load_index;
  logic [tbr_pkg::PIXEL_W-1:0] load_pixel;
  modport source(output valid, op, load_index, load_pixel, input ready);
  modport sink(input valid, op, load_index, load_pixel, output ready);
endinterface

interface tbr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tbr_pkg::PIXEL_W-1:0] out_pixel;
  logic                        frame_last;
  modport source(output valid, out_pixel, frame_last, input ready);
  modport sink(input valid, out_pixel, frame_last, output ready);
endinterface

interface tbr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tbr_pkg::CFG_IDX_W-1:0] index;
  logic [tbr_pkg::DIM_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/tbr_front.sv @@
// Front end: accepts input beats, decodes them and queues the work
module tbr_front (
  tbr_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output tbr_pkg::item_t  q_item
);
  import tbr_pkg::*;

  logic accept;
  logic in_range;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.load_index) < IMAGE_DEPTH;

  always_comb begin
    q_item.kind  = (in_ch.op == OP_EMIT) ? KIND_EMIT : KIND_LOAD;
    q_item.index = in_ch.load_index;
    q_item.pixel = in_ch.load_pixel;
  end

  // loads that fall outside the store are swallowed here
  assign q_push = accept && ((in_ch.op == OP_EMIT) || in_range);

endmodule

@@ rtl/tbr_fifo.sv @@
// Short queue between front and back end
module tbr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tbr_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output tbr_pkg::item_t  head,
  output logic            empty
);
  import tbr_pkg::*;

  item_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ rtl/tbr_div.sv @@
// Serial restoring divider, one quotient bit per cycle
module tbr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tbr_pkg::div_req_t req,
  output tbr_pkg::div_rsp_t rsp
);
  import tbr_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    divs_r;
  logic                 done_r;

  logic [DIVS_W:0]      shifted;
  logic [DIVS_W+1:0]    diff;
  logic                 ge;
  logic [DIVS_W-1:0]    rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divs_r};
    ge      = !diff[DIVS_W+1];
    rem_nxt = ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r  <= req.dividend;
      rem_r  <= '0;
      divs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= DIV_CNT_W'(DIVD_W);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_comb begin
    rsp.busy     = (cnt_r != '0);
    rsp.done     = done_r;
    rsp.quotient = quo_r;
  end

endmodule

@@ rtl/tbr_back.sv @@
// Back end: image store, address generation, four-tap average, result register
module tbr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tbr_pkg::cfg_wr_t    cfg_wr,
  input  logic                q_empty,
  input  tbr_pkg::item_t      q_head,
  output logic                q_pop,
  output tbr_pkg::div_req_t   div_req,
  input  tbr_pkg::div_rsp_t   div_rsp,
  tbr_out_if.source           out_ch,
  output tbr_pkg::bk_status_t status
);
  import tbr_pkg::*;

  back_state_t state_r, state_nxt;

  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [DIM_W-1:0] sw, sh, dw, dh;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             frac_ok_r;
  logic             row_ok_r;

  logic [FSTEP_W-1:0] frac_r;
  logic [DIM_W-1:0]   r1_r, r2_r;
  logic [RSW_W-1:0]   rsw1_r, rsw2_r;
  logic [BASE_W-1:0]  base_r;
  logic [C_W-1:0]     c1_r, c2_r;

  logic [PIXEL_W-1:0] store [IMAGE_DEPTH];
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [PIXEL_W-1:0] rd_data_r;

  logic [LANES-1:0][LSUM_W-1:0] acc_r;
  logic [LANES-1:0][LSUM_W-1:0] acc_add;
  logic [LANES-1:0][LSUM_W-1:0] lanes_in;
  logic [PIXEL_W-1:0]           avg;

  logic               out_valid_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic               frame_last_r;
  logic               fin_take;

  logic [DIVD_W-1:0]  row_num1, row_num3;
  logic [FSTEP_W-1:0] quarter;
  logic [SUM_W-1:0]   sum1, sum2;
  logic [RSW_W:0]     addr_sum;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic               col_wrap;
  logic               last_px;

  assign sw = eff_dim(src_w_r, DIM_W'(MAX_SRC_DIM));
  assign sh = eff_dim(src_h_r, DIM_W'(MAX_SRC_DIM));
  assign dw = eff_dim(dst_w_r, DIM_W'(MAX_DST_WIDTH));
  assign dh = eff_dim(dst_h_r, DIM_W'(MAX_DST_HEIGHT));

  // Row numerators (4i+1)*sh and (4i+3)*sh
  assign row_num1 = DIVD_W'({row_r, 2'b01}) * DIVD_W'(sh);
  assign row_num3 = DIVD_W'({row_r, 2'b11}) * DIVD_W'(sh);

  assign quarter = frac_r >> 2;
  assign sum1    = SUM_W'(quarter) + SUM_W'(base_r);
  assign sum2    = SUM_W'(quarter) + SUM_W'({quarter, 1'b0}) + SUM_W'(base_r);

  assign col_inc  = DIM_W'(col_r) + 1'b1;
  assign row_inc  = DIM_W'(row_r) + 1'b1;
  assign col_wrap = (col_inc >= dw);
  assign last_px  = (DIM_W'(row_r) == dh - 1'b1) && (DIM_W'(col_r) == dw - 1'b1);

  assign fin_take = (state_r == BK_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      lanes_in[l] = LSUM_W'(rd_data_r[l*LANE_W +: LANE_W]);
      acc_add[l]  = acc_r[l] + lanes_in[l];
      avg[l*LANE_W +: LANE_W] = acc_add[l][LSUM_W-1:2];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && (q_head.kind == KIND_EMIT)) begin
          if (!frac_ok_r)     state_nxt = BK_DIVF_GO;
          else if (!row_ok_r) state_nxt = BK_DIVR1_GO;
          else                state_nxt = BK_COL_MUL;
        end
      end
      BK_DIVF_GO:    state_nxt = BK_DIVF_WAIT;
      BK_DIVF_WAIT: begin
        if (div_rsp.done) state_nxt = row_ok_r ? BK_COL_MUL : BK_DIVR1_GO;
      end
      BK_DIVR1_GO:   state_nxt = BK_DIVR1_WAIT;
      BK_DIVR1_WAIT: if (div_rsp.done) state_nxt = BK_DIVR2_GO;
      BK_DIVR2_GO:   state_nxt = BK_DIVR2_WAIT;
      BK_DIVR2_WAIT: if (div_rsp.done) state_nxt = BK_ROW_MUL;
      BK_ROW_MUL:    state_nxt = BK_COL_MUL;
      BK_COL_MUL:    state_nxt = BK_COL_ADD;
      BK_COL_ADD:    state_nxt = BK_RD0;
      BK_RD0:        state_nxt = BK_RD1;
      BK_RD1:        state_nxt = BK_RD2;
      BK_RD2:        state_nxt = BK_RD3;
      BK_RD3:        state_nxt = BK_FIN;
      BK_FIN:        if (fin_take) state_nxt = BK_IDLE;
      default:       state_nxt = BK_IDLE;
    endcase
  end

  // state-decoded controls
  always_comb begin
    q_pop            = (state_r == BK_IDLE) && !q_empty;
    wr_en            = q_pop && (q_head.kind == KIND_LOAD);
    wr_addr          = ADDR_W'(q_head.index);
    div_req.start    = state_r inside {BK_DIVF_GO, BK_DIVR1_GO, BK_DIVR2_GO};
    div_req.dividend = '0;
    div_req.divisor  = DIVS_W'({dh, 2'b00});
    rd_en            = state_r inside {[BK_RD0:BK_RD3]};
    addr_sum         = '0;
    case (state_r)
      BK_DIVF_GO: begin
        div_req.dividend = DIVD_W'({sw, FRAC_W'(0)});
        div_req.divisor  = DIVS_W'(dw);
      end
      BK_DIVR1_GO: div_req.dividend = row_num1;
      BK_DIVR2_GO: div_req.dividend = row_num3;
      BK_RD0:      addr_sum = (RSW_W+1)'(rsw1_r) + (RSW_W+1)'(c1_r);
      BK_RD1:      addr_sum = (RSW_W+1)'(rsw1_r) + (RSW_W+1)'(c2_r);
      BK_RD2:      addr_sum = (RSW_W+1)'(rsw2_r) + (RSW_W+1)'(c1_r);
      BK_RD3:      addr_sum = (RSW_W+1)'(rsw2_r) + (RSW_W+1)'(c2_r);
      default:     addr_sum = '0;
    endcase
    // address wraps modulo the store depth
    rd_addr = ADDR_W'(addr_sum);
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= q_head.pixel;
    if (rd_en) rd_data_r <= store[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      BK_DIVF_WAIT:  if (div_rsp.done) frac_r <= FSTEP_W'(div_rsp.quotient);
      BK_DIVR1_WAIT: if (div_rsp.done) r1_r <= DIM_W'(div_rsp.quotient);
      BK_DIVR2_WAIT: if (div_rsp.done) r2_r <= DIM_W'(div_rsp.quotient);
      BK_ROW_MUL: begin
        rsw1_r <= RSW_W'(r1_r) * RSW_W'(sw);
        rsw2_r <= RSW_W'(r2_r) * RSW_W'(sw);
      end
      BK_COL_MUL: base_r <= BASE_W'(col_r) * BASE_W'(frac_r);
      BK_COL_ADD: begin
        c1_r <= sum1[SUM_W-1:FRAC_W];
        c2_r <= sum2[SUM_W-1:FRAC_W];
      end
      BK_RD1:  acc_r <= lanes_in;
      BK_RD2:  acc_r <= acc_add;
      BK_RD3:  acc_r <= acc_add;
      default: acc_r <= acc_r;
    endcase
    if (fin_take) begin
      out_pixel_r  <= avg;
      frame_last_r <= last_px;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      src_w_r     <= DIM_W'(1);
      src_h_r     <= DIM_W'(1);
      dst_w_r     <= DIM_W'(1);
      dst_h_r     <= DIM_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      frac_ok_r   <= 1'b0;
      row_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_DIVF_WAIT && div_rsp.done) frac_ok_r <= 1'b1;
      if (state_r == BK_ROW_MUL) row_ok_r <= 1'b1;

      if (fin_take) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (fin_take) begin
        if (col_wrap) begin
          col_r    <= '0;
          row_ok_r <= 1'b0;
          row_r    <= (row_inc >= dh) ? '0 : ROW_W'(row_inc);
        end else begin
          col_r <= COL_W'(col_inc);
        end
      end

      // any register write restarts the frame and drops cached divisions
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          REG_SRC_WIDTH:  src_w_r <= cfg_wr.data;
          REG_SRC_HEIGHT: src_h_r <= cfg_wr.data;
          REG_DST_WIDTH:  dst_w_r <= cfg_wr.data;
          REG_DST_HEIGHT: dst_h_r <= cfg_wr.data;
          default:        ;
        endcase
        col_r     <= '0;
        row_r     <= '0;
        frac_ok_r <= 1'b0;
        row_ok_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_pixel  = out_pixel_r;
  assign out_ch.frame_last = frame_last_r;

  always_comb begin
    status.busy      = (state_r != BK_IDLE);
    status.at_origin = (col_r == '0) && (row_r == '0);
  end

endmodule

@@ rtl/texture_box_resample.sv @@
// Top level of the two-by-two box filter resampler
// Load beats write one source pixel into the image store; emit beats return the next
// output pixel in raster order, each the per-lane average of four source pixels. A load
// is written into the store while the back end stays idle. An emit is paced by the four reads
// through the single read port of the image store plus address setup. The first emit after
// a register write adds one serial division for the column step, and the first emit of
// each output row adds two more such divisions for the row pair plus a multiply. A
// four-entry queue sits between input and back end, and the result register lets the back
// end keep draining loads while a result waits. The store has no clearing pass and no
// reset; a register write restarts output at the first pixel of the frame.
`include "texture_box_resample_macros.svh"

module texture_box_resample (
  input  logic       clk,
  input  logic       rst_n,
  tbr_in_if.sink     in_ch,
  tbr_out_if.source  out_ch,
  tbr_cfg_if.sink    cfg_ch
);
  import tbr_pkg::*;

  logic       q_push;
  item_t      q_item;
  logic       q_full;
  logic       q_pop;
  item_t      q_head;
  logic       q_empty;
  cfg_wr_t    cfg_wr;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  bk_status_t bk_status;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_wr.valid = cfg_ch.valid && cfg_ch.ready;
    cfg_wr.index = cfg_ch.index;
    cfg_wr.data  = cfg_ch.data;
  end

  tbr_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_item)
  );

  tbr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  tbr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tbr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch),
    .status  (bk_status)
  );

  `TBR_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `TBR_ASSERT_NOW(a_div_done_busy, div_rsp.done, bk_status.busy, "divider result with idle back end")
  `TBR_ASSERT_NEXT(a_cfg_restart, cfg_ch.valid && cfg_ch.ready, bk_status.at_origin, "frame not restarted by register write")

endmodule
